>>> sv/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Types and constants shared by the point rigid-transform block.
// ----------------------------------------------------------------------------
package prt_pkg;

   localparam int COORD_W = 24;   // point coordinate, signed mm
   localparam int QUAT_W  = 16;   // quaternion component, Q1.14
   localparam int REFL_W  = 8;    // intensity
   localparam int IDX_W   = 3;    // csr register index
   localparam int DATA_W  = 24;   // csr write data

   localparam int COORD_MAX = 8388607;
   localparam int COORD_MIN = -8388608;

   // register indexes
   localparam logic [IDX_W-1:0] REG_ROT_W   = 3'd0;
   localparam logic [IDX_W-1:0] REG_ROT_X   = 3'd1;
   localparam logic [IDX_W-1:0] REG_ROT_Y   = 3'd2;
   localparam logic [IDX_W-1:0] REG_ROT_Z   = 3'd3;
   localparam logic [IDX_W-1:0] REG_SHIFT_X = 3'd4;
   localparam logic [IDX_W-1:0] REG_SHIFT_Y = 3'd5;
   localparam logic [IDX_W-1:0] REG_SHIFT_Z = 3'd6;

   localparam logic signed [QUAT_W-1:0] ROT_W_RESET = 16'sd16384;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [QUAT_W-1:0]  quat_type;

   typedef struct packed {
      quat_type  rot_w;
      quat_type  rot_x;
      quat_type  rot_y;
      quat_type  rot_z;
      coord_type shift_x;
      coord_type shift_y;
      coord_type shift_z;
   } cfg_type;

   typedef struct packed {
      coord_type          pos_x;
      coord_type          pos_y;
      coord_type          pos_z;
      logic [REFL_W-1:0]  reflect;
      logic               last_point;
   } req_item_type;

   typedef struct packed {
      coord_type          out_x;
      coord_type          out_y;
      coord_type          out_z;
      logic [REFL_W-1:0]  out_reflect;
      logic               out_last;
      logic               clipped;
   } rsp_item_type;

endpackage

>>> sv/prt_if.sv
// ----------------------------------------------------------------------------
// prt_if
// Valid/ready channels of the point rigid-transform block.
// ----------------------------------------------------------------------------
interface prt_req_if;
   logic                          valid;
   logic                          ready;
   prt_pkg::coord_type            pos_x;
   prt_pkg::coord_type            pos_y;
   prt_pkg::coord_type            pos_z;
   logic [prt_pkg::REFL_W-1:0]    reflect;
   logic                          last_point;

   modport source (output valid, pos_x, pos_y, pos_z, reflect, last_point,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, reflect, last_point,
                   output ready);
endinterface

interface prt_rsp_if;
   logic                          valid;
   logic                          ready;
   prt_pkg::coord_type            out_x;
   prt_pkg::coord_type            out_y;
   prt_pkg::coord_type            out_z;
   logic [prt_pkg::REFL_W-1:0]    out_reflect;
   logic                          out_last;
   logic                          clipped;

   modport source (output valid, out_x, out_y, out_z, out_reflect, out_last, clipped,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_reflect, out_last, clipped,
                   output ready);
endinterface

interface prt_csr_if;
   logic                          valid;
   logic                          ready;
   logic [prt_pkg::IDX_W-1:0]     index;
   logic [prt_pkg::DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/point_rigid_transform.sv
// An accepted request passes through the five pipeline registers, each
// holding a point, before rsp_bus.valid. Throughput: one point per cycle
// while rsp_bus.ready is high; the widest multiply is 16 x 42 bits.
// Reset (synchronous, active high): pipeline emptied, rotation set to the
// identity quaternion, translation cleared.
// ----------------------------------------------------------------------------
// point_rigid_transform
// Rotates each point by a unit quaternion and adds a translation, saturating
// the result to 24 bits signed.
// ----------------------------------------------------------------------------
module point_rigid_transform (
   input  logic      clock,
   input  logic      reset,
   prt_req_if.sink   req_bus,
   prt_rsp_if.source rsp_bus,
   prt_csr_if.sink   csr_bus
);

   // Configuration registers, to be written by the user only while the pipe is
   // idle (the block does not enforce it); stages read them directly, no copy per point.
   prt_pkg::cfg_type cfg_ff;
   prt_pkg::cfg_type cfg_in;

   prt_pkg::req_item_type req_item;
   prt_pkg::rsp_item_type rsp_item;

   logic csr_write;

   // csr channel never back-pressures; unknown indexes are dropped
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid & csr_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_bus.index)
            prt_pkg::REG_ROT_W:   cfg_in.rot_w   = csr_bus.data[prt_pkg::QUAT_W-1:0];
            prt_pkg::REG_ROT_X:   cfg_in.rot_x   = csr_bus.data[prt_pkg::QUAT_W-1:0];
            prt_pkg::REG_ROT_Y:   cfg_in.rot_y   = csr_bus.data[prt_pkg::QUAT_W-1:0];
            prt_pkg::REG_ROT_Z:   cfg_in.rot_z   = csr_bus.data[prt_pkg::QUAT_W-1:0];
            prt_pkg::REG_SHIFT_X: cfg_in.shift_x = csr_bus.data[prt_pkg::COORD_W-1:0];
            prt_pkg::REG_SHIFT_Y: cfg_in.shift_y = csr_bus.data[prt_pkg::COORD_W-1:0];
            prt_pkg::REG_SHIFT_Z: cfg_in.shift_z = csr_bus.data[prt_pkg::COORD_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_w   <= prt_pkg::ROT_W_RESET;
         cfg_ff.rot_x   <= '0;
         cfg_ff.rot_y   <= '0;
         cfg_ff.rot_z   <= '0;
         cfg_ff.shift_x <= '0;
         cfg_ff.shift_y <= '0;
         cfg_ff.shift_z <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request payload into the pipe
   assign req_item.pos_x      = req_bus.pos_x;
   assign req_item.pos_y      = req_bus.pos_y;
   assign req_item.pos_z      = req_bus.pos_z;
   assign req_item.reflect    = req_bus.reflect;
   assign req_item.last_point = req_bus.last_point;

   // Stages: v*p products, cross product c, w*c and v*c products,
   // exact sum with rounding, translate and clip (output register).
   prt_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_item   (req_item),
      .cfg       (cfg_ff),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_item  (rsp_item)
   );

   assign rsp_bus.out_x       = rsp_item.out_x;
   assign rsp_bus.out_y       = rsp_item.out_y;
   assign rsp_bus.out_z       = rsp_item.out_z;
   assign rsp_bus.out_reflect = rsp_item.out_reflect;
   assign rsp_bus.out_last    = rsp_item.out_last;
   assign rsp_bus.clipped     = rsp_item.clipped;

endmodule

>>> sv/prt_pipe.sv
// ----------------------------------------------------------------------------
// prt_pipe
// Five-stage rotate/translate datapath with per-stage valids and stall.
// ----------------------------------------------------------------------------
module prt_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  prt_pkg::req_item_type in_item,
   input  prt_pkg::cfg_type      cfg,
   output logic                  out_valid,
   input  logic                  out_ready,
   output prt_pkg::rsp_item_type out_item
);

   localparam int STAGES = 5;
   localparam int PROD_W = prt_pkg::QUAT_W + prt_pkg::COORD_W;   // 40
   localparam int C_W    = PROD_W + 2;                           // 42
   localparam int WC_W   = prt_pkg::QUAT_W + C_W;                // 58
   localparam int S_W    = 60;
   localparam int FRAC   = 28;
   localparam int R_W    = S_W - FRAC;                           // 32
   localparam int SUM_W  = R_W + 1;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [C_W-1:0]    cvec_type;
   typedef logic signed [WC_W-1:0]   wide_type;
   typedef logic signed [R_W-1:0]    rnd_type;

   typedef struct packed {
      logic [prt_pkg::REFL_W-1:0] reflect;
      logic                       last_point;
   } meta_type;

   typedef struct packed {
      prt_pkg::coord_type px, py, pz;
      meta_type           meta;
      prod_type           yz, zy, zx, xz, xy, yx;
   } st1_type;

   typedef struct packed {
      prt_pkg::coord_type px, py, pz;
      meta_type           meta;
      cvec_type           cx, cy, cz;
   } st2_type;

   typedef struct packed {
      prt_pkg::coord_type px, py, pz;
      meta_type           meta;
      wide_type           wcx, wcy, wcz;
      wide_type           ax, bx, ay, by, az, bz;
   } st3_type;

   typedef struct packed {
      meta_type meta;
      rnd_type  rx, ry, rz;
   } st4_type;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   rdy;

   st1_type st1_ff, st1_in;
   st2_type st2_ff, st2_in;
   st3_type st3_ff, st3_in;
   st4_type st4_ff, st4_in;
   prt_pkg::rsp_item_type st5_ff, st5_in;

   // ready ripples back: a stage loads when empty or its successor moves
   always_comb begin
      rdy[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_item  = st5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // stage 1: p times v components
   always_comb begin
      st1_in.px = in_item.pos_x;
      st1_in.py = in_item.pos_y;
      st1_in.pz = in_item.pos_z;
      st1_in.meta.reflect    = in_item.reflect;
      st1_in.meta.last_point = in_item.last_point;
      st1_in.yz = cfg.rot_y * in_item.pos_z;
      st1_in.zy = cfg.rot_z * in_item.pos_y;
      st1_in.zx = cfg.rot_z * in_item.pos_x;
      st1_in.xz = cfg.rot_x * in_item.pos_z;
      st1_in.xy = cfg.rot_x * in_item.pos_y;
      st1_in.yx = cfg.rot_y * in_item.pos_x;
   end

   // stage 2: c = 2 (v x p)
   always_comb begin
      st2_in.px   = st1_ff.px;
      st2_in.py   = st1_ff.py;
      st2_in.pz   = st1_ff.pz;
      st2_in.meta = st1_ff.meta;
      st2_in.cx   = (C_W'(st1_ff.yz) - C_W'(st1_ff.zy)) <<< 1;
      st2_in.cy   = (C_W'(st1_ff.zx) - C_W'(st1_ff.xz)) <<< 1;
      st2_in.cz   = (C_W'(st1_ff.xy) - C_W'(st1_ff.yx)) <<< 1;
   end

   // stage 3: w*c and the v x c partial products
   always_comb begin
      st3_in.px   = st2_ff.px;
      st3_in.py   = st2_ff.py;
      st3_in.pz   = st2_ff.pz;
      st3_in.meta = st2_ff.meta;
      st3_in.wcx  = cfg.rot_w * st2_ff.cx;
      st3_in.wcy  = cfg.rot_w * st2_ff.cy;
      st3_in.wcz  = cfg.rot_w * st2_ff.cz;
      st3_in.ax   = cfg.rot_y * st2_ff.cz;
      st3_in.bx   = cfg.rot_z * st2_ff.cy;
      st3_in.ay   = cfg.rot_z * st2_ff.cx;
      st3_in.by   = cfg.rot_x * st2_ff.cz;
      st3_in.az   = cfg.rot_x * st2_ff.cy;
      st3_in.bz   = cfg.rot_y * st2_ff.cx;
   end

   // stage 4: exact sum in 2^-28 mm, then round half up
   function automatic rnd_type sum_round(prt_pkg::coord_type p, wide_type wc,
                                         wide_type a, wide_type b);
      logic signed [S_W-1:0] s;
      s = {{(S_W-prt_pkg::COORD_W-FRAC){p[prt_pkg::COORD_W-1]}}, p, {FRAC{1'b0}}}
          + S_W'(wc) + S_W'(a) - S_W'(b) + (S_W'(1) <<< (FRAC - 1));
      return s[S_W-1:FRAC];
   endfunction

   always_comb begin
      st4_in.meta = st3_ff.meta;
      st4_in.rx   = sum_round(st3_ff.px, st3_ff.wcx, st3_ff.ax, st3_ff.bx);
      st4_in.ry   = sum_round(st3_ff.py, st3_ff.wcy, st3_ff.ay, st3_ff.by);
      st4_in.rz   = sum_round(st3_ff.pz, st3_ff.wcz, st3_ff.az, st3_ff.bz);
   end

   // stage 5: translate and saturate
   function automatic logic [prt_pkg::COORD_W:0] shift_sat(rnd_type r,
                                                            prt_pkg::coord_type t);
      logic signed [SUM_W-1:0] v;
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(prt_pkg::COORD_MAX);
      lo = SUM_W'(prt_pkg::COORD_MIN);
      v  = SUM_W'(r) + SUM_W'(t);
      if (v > hi) begin
         return {1'b1, hi[prt_pkg::COORD_W-1:0]};
      end else if (v < lo) begin
         return {1'b1, lo[prt_pkg::COORD_W-1:0]};
      end
      return {1'b0, v[prt_pkg::COORD_W-1:0]};
   endfunction

   always_comb begin
      logic [prt_pkg::COORD_W:0] sx, sy, sz;
      sx = shift_sat(st4_ff.rx, cfg.shift_x);
      sy = shift_sat(st4_ff.ry, cfg.shift_y);
      sz = shift_sat(st4_ff.rz, cfg.shift_z);
      st5_in.out_x       = sx[prt_pkg::COORD_W-1:0];
      st5_in.out_y       = sy[prt_pkg::COORD_W-1:0];
      st5_in.out_z       = sz[prt_pkg::COORD_W-1:0];
      st5_in.out_reflect = st4_ff.meta.reflect;
      st5_in.out_last    = st4_ff.meta.last_point;
      st5_in.clipped     = sx[prt_pkg::COORD_W] | sy[prt_pkg::COORD_W]
                         | sz[prt_pkg::COORD_W];
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         st1_ff <= st1_in;
      end
      if (rdy[1]) begin
         st2_ff <= st2_in;
      end
      if (rdy[2]) begin
         st3_ff <= st3_in;
      end
      if (rdy[3]) begin
         st4_ff <= st4_in;
      end
      if (rdy[4]) begin
         st5_ff <= st5_in;
      end
   end

endmodule

>>> sv/prt_checker.sv
// ----------------------------------------------------------------------------
// prt_checker
// Port-level checks for the point rigid-transform block.
// ----------------------------------------------------------------------------
module prt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input prt_pkg::coord_type out_x,
   input prt_pkg::coord_type out_y,
   input prt_pkg::coord_type out_z,
   input logic               clipped
);

   function automatic logic at_rail(prt_pkg::coord_type c);
      return (c == prt_pkg::coord_type'(prt_pkg::COORD_MAX))
          || (c == prt_pkg::coord_type'(prt_pkg::COORD_MIN));
   endfunction

   // a stalled request result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({out_x, out_y, out_z, clipped}))
      else $error("rsp payload changed while stalled");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // clip flag only with a coordinate on a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clipped |-> at_rail(out_x) || at_rail(out_y) || at_rail(out_z))
      else $error("clipped set with no saturated coordinate");

   // an empty output stage means the whole pipe can move
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind point_rigid_transform prt_checker u_prt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .out_x     (rsp_bus.out_x),
   .out_y     (rsp_bus.out_y),
   .out_z     (rsp_bus.out_z),
   .clipped   (rsp_bus.clipped)
);
